// File: rtl/tcst_pkg.sv
package tcst_pkg;

    localparam int unsigned SEQ_W   = 32;
    localparam int unsigned STATE_W = 4;
    localparam int unsigned SLACK_W = 16;

    localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd1460;

    // Connection states
    localparam logic [STATE_W-1:0] ST_UNKNOWN      = 4'd0;
    localparam logic [STATE_W-1:0] ST_CLOSED       = 4'd1;
    localparam logic [STATE_W-1:0] ST_SYN_SENT     = 4'd2;
    localparam logic [STATE_W-1:0] ST_SYN_RECEIVED = 4'd3;
    localparam logic [STATE_W-1:0] ST_ESTABLISHED  = 4'd4;
    localparam logic [STATE_W-1:0] ST_FIN_WAIT1    = 4'd5;
    localparam logic [STATE_W-1:0] ST_FIN_WAIT2    = 4'd6;
    localparam logic [STATE_W-1:0] ST_CLOSE_WAIT   = 4'd7;
    localparam logic [STATE_W-1:0] ST_CLOSING      = 4'd8;
    localparam logic [STATE_W-1:0] ST_LAST_ACK     = 4'd9;
    localparam logic [STATE_W-1:0] ST_TIME_WAIT    = 4'd10;

    typedef struct packed {
        logic             syn_bit;
        logic             ack_bit;
        logic             fin_bit;
        logic             rst_bit;
        logic [SEQ_W-1:0] seq_number;
        logic [SEQ_W-1:0] ack_number;
        logic             from_initiator;
    } pkt_t;

    typedef struct packed {
        logic shutdown_done;
        logic reset_seen;
        logic fin_responder;
        logic fin_initiator;
        logic handshake_done;
        logic synack_rcvd;
        logic syn_opened;
    } flags_t;

    typedef struct packed {
        logic [STATE_W-1:0] conn_state;
        flags_t             flags;
        logic [SEQ_W-1:0]   retrans_count;
        logic [SEQ_W-1:0]   reorder_count;
        logic [SEQ_W-1:0]   initiator_last_ack;
        logic [SEQ_W-1:0]   responder_last_ack;
    } result_t;

    // Register stage handshake between two modules
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

// File: rtl/tcp_connection_state_tracker_unit.sv
// TCP connection state tracker: follows one connection from packet headers
// (SYN/ACK/FIN/RST, sequence and ack numbers, direction) and returns one result
// per packet with the connection state after that packet, the latched status
// flags, saturating retransmit/reorder counts and the last ack per side. It
// takes one packet per clock while m_ready does not hold it back; a packet is
// held in the input register and its result is captured in the result register,
// which drives the m_ ports. The update of the connection state is a single
// pass of compare-and-select logic between the two registers.
// s_ready only drops when both registers hold items and m_ready is low.
// segment_slack (reset 1460) is written through cfg_we/cfg_wdata and should
// only be changed while no packet is in flight.
module tcp_connection_state_tracker_unit
    import tcst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    // Configuration: segment_slack
    input  logic               cfg_we,
    input  logic [SLACK_W-1:0] cfg_wdata,

    // Packet input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_syn_bit,
    input  logic               s_ack_bit,
    input  logic               s_fin_bit,
    input  logic               s_rst_bit,
    input  logic [SEQ_W-1:0]   s_seq_number,
    input  logic [SEQ_W-1:0]   s_ack_number,
    input  logic               s_from_initiator,

    // Result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STATE_W-1:0] m_conn_state,
    output logic               m_syn_seen,
    output logic               m_syn_ack_seen,
    output logic               m_handshake_done,
    output logic               m_fin_initiator,
    output logic               m_fin_responder,
    output logic               m_reset_seen,
    output logic               m_shutdown_done,
    output logic [SEQ_W-1:0]   m_retrans_count,
    output logic [SEQ_W-1:0]   m_reorder_count,
    output logic [SEQ_W-1:0]   m_initiator_last_ack,
    output logic [SEQ_W-1:0]   m_responder_last_ack
);

    pkt_t    s_pkt;
    pkt_t    cur_pkt;
    hs_t     core_hs;
    logic    res_ready;
    result_t core_result;
    result_t m_result;

    assign s_pkt.syn_bit        = s_syn_bit;
    assign s_pkt.ack_bit        = s_ack_bit;
    assign s_pkt.fin_bit        = s_fin_bit;
    assign s_pkt.rst_bit        = s_rst_bit;
    assign s_pkt.seq_number     = s_seq_number;
    assign s_pkt.ack_number     = s_ack_number;
    assign s_pkt.from_initiator = s_from_initiator;

    // Input register: holds the packet being processed this cycle
    tcst_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pkt    (s_pkt),
        .out_hs_o  (core_hs),
        .out_ready (res_ready),
        .out_pkt   (cur_pkt)
    );

    // Connection state and counters; commit when the packet moves on to the
    // result register, so state and result always advance together
    tcst_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .hs        (core_hs),
        .pkt       (cur_pkt),
        .result    (core_result)
    );

    // Result register: decouples the consumer's back-pressure
    tcst_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (core_hs.valid),
        .in_ready   (res_ready),
        .in_result  (core_result),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (m_result)
    );

    assign m_conn_state         = m_result.conn_state;
    assign m_syn_seen           = m_result.flags.syn_opened;
    assign m_syn_ack_seen       = m_result.flags.synack_rcvd;
    assign m_handshake_done     = m_result.flags.handshake_done;
    assign m_fin_initiator      = m_result.flags.fin_initiator;
    assign m_fin_responder      = m_result.flags.fin_responder;
    assign m_reset_seen         = m_result.flags.reset_seen;
    assign m_shutdown_done      = m_result.flags.shutdown_done;
    assign m_retrans_count      = m_result.retrans_count;
    assign m_reorder_count      = m_result.reorder_count;
    assign m_initiator_last_ack = m_result.initiator_last_ack;
    assign m_responder_last_ack = m_result.responder_last_ack;

endmodule

// File: rtl/tcst_in_stage.sv
module tcst_in_stage
    import tcst_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  pkt_t in_pkt,
    output hs_t  out_hs_o,
    input  logic out_ready,
    output pkt_t out_pkt
);

    logic valid_reg;
    logic valid_next;
    pkt_t pkt_reg;

    // Stage empties or moves on in the same cycle: full rate while the next stage is ready.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pkt_reg <= in_pkt;
        end
    end

    assign out_hs_o.valid = valid_reg;
    assign out_hs_o.ready = out_ready;
    assign out_pkt        = pkt_reg;

endmodule

// File: rtl/tcst_core.sv
module tcst_core
    import tcst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [SLACK_W-1:0] cfg_wdata,
    input  hs_t                hs,
    input  pkt_t               pkt,
    output result_t            result
);

    logic               fire;
    logic [SLACK_W-1:0] slack_reg;
    logic [STATE_W-1:0] state_reg, state_next;
    flags_t             flags_reg, flags_next;
    logic [SEQ_W-1:0]   i_seq_reg, i_seq_next;
    logic [SEQ_W-1:0]   r_seq_reg, r_seq_next;
    logic [SEQ_W-1:0]   i_ack_reg, i_ack_next;
    logic [SEQ_W-1:0]   r_ack_reg, r_ack_next;
    logic [SEQ_W-1:0]   retrans_reg, retrans_next;
    logic [SEQ_W-1:0]   reorder_reg, reorder_next;

    logic [SEQ_W-1:0]   seq_store;
    logic [SEQ_W:0]     seq_limit;
    logic               seq_check;
    logic               is_retrans;
    logic               is_reorder;

    assign fire = hs.valid && hs.ready;

    // Sequence check against the sender's side; limit kept one bit wider
    assign seq_store  = pkt.from_initiator ? i_seq_reg : r_seq_reg;
    assign seq_limit  = {1'b0, seq_store} + {{(SEQ_W + 1 - SLACK_W){1'b0}}, slack_reg};
    assign seq_check  = !pkt.rst_bit && !pkt.syn_bit && !pkt.fin_bit && (seq_store != '0);
    assign is_retrans = seq_check && (pkt.seq_number < seq_store);
    assign is_reorder = seq_check && !is_retrans && ({1'b0, pkt.seq_number} > seq_limit);

    always_comb begin
        state_next   = state_reg;
        flags_next   = flags_reg;
        i_seq_next   = i_seq_reg;
        r_seq_next   = r_seq_reg;
        i_ack_next   = i_ack_reg;
        r_ack_next   = r_ack_reg;
        retrans_next = retrans_reg;
        reorder_next = reorder_reg;

        if (pkt.rst_bit) begin
            flags_next.reset_seen    = 1'b1;
            flags_next.shutdown_done = 1'b1;
            state_next               = ST_CLOSED;
        end else if (pkt.syn_bit && !pkt.ack_bit) begin
            if (state_reg == ST_UNKNOWN || state_reg == ST_CLOSED) begin
                flags_next.syn_opened = 1'b1;
                state_next            = ST_SYN_SENT;
            end
            if (pkt.from_initiator) begin
                i_seq_next = pkt.seq_number;
            end
        end else if (pkt.syn_bit) begin
            if (state_reg == ST_SYN_SENT) begin
                flags_next.synack_rcvd = 1'b1;
                state_next             = ST_SYN_RECEIVED;
            end
            if (!pkt.from_initiator) begin
                r_seq_next = pkt.seq_number;
                r_ack_next = pkt.ack_number;
            end
        end else if (pkt.fin_bit) begin
            if (pkt.from_initiator) begin
                flags_next.fin_initiator = 1'b1;
            end else begin
                flags_next.fin_responder = 1'b1;
            end
            case (state_reg)
                ST_ESTABLISHED: begin
                    state_next = pkt.from_initiator ? ST_FIN_WAIT1 : ST_CLOSE_WAIT;
                end
                default: begin
                    if (state_reg == ST_FIN_WAIT2 && !pkt.from_initiator) begin
                        state_next = ST_TIME_WAIT;
                    end else if (state_reg == ST_CLOSE_WAIT && !pkt.from_initiator) begin
                        state_next = ST_LAST_ACK;
                    end else if (state_reg == ST_FIN_WAIT1 && !pkt.from_initiator) begin
                        state_next = ST_CLOSING;
                    end else if (flags_next.fin_initiator && flags_next.fin_responder) begin
                        flags_next.shutdown_done = 1'b1;
                    end
                end
            endcase
        end else begin
            if (pkt.ack_bit) begin
                case (state_reg)
                    ST_SYN_RECEIVED: begin
                        if (pkt.from_initiator) begin
                            flags_next.handshake_done = 1'b1;
                            state_next                = ST_ESTABLISHED;
                        end
                    end
                    ST_FIN_WAIT1: state_next = ST_FIN_WAIT2;
                    ST_CLOSING:   state_next = ST_TIME_WAIT;
                    ST_LAST_ACK: begin
                        state_next               = ST_CLOSED;
                        flags_next.shutdown_done = 1'b1;
                    end
                    default: ;
                endcase
                if (pkt.from_initiator) begin
                    i_ack_next = pkt.ack_number;
                end else begin
                    r_ack_next = pkt.ack_number;
                end
            end
            if (seq_check) begin
                if (pkt.from_initiator) begin
                    i_seq_next = pkt.seq_number;
                end else begin
                    r_seq_next = pkt.seq_number;
                end
            end
            if (is_retrans && retrans_reg != '1) begin
                retrans_next = retrans_reg + 1'b1;
            end
            if (is_reorder && reorder_reg != '1) begin
                reorder_next = reorder_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slack_reg   <= SLACK_RESET;
            state_reg   <= ST_UNKNOWN;
            flags_reg   <= '0;
            i_seq_reg   <= '0;
            r_seq_reg   <= '0;
            i_ack_reg   <= '0;
            r_ack_reg   <= '0;
            retrans_reg <= '0;
            reorder_reg <= '0;
        end else begin
            if (cfg_we) begin
                slack_reg <= cfg_wdata;
            end
            if (fire) begin
                state_reg   <= state_next;
                flags_reg   <= flags_next;
                i_seq_reg   <= i_seq_next;
                r_seq_reg   <= r_seq_next;
                i_ack_reg   <= i_ack_next;
                r_ack_reg   <= r_ack_next;
                retrans_reg <= retrans_next;
                reorder_reg <= reorder_next;
            end
        end
    end

    assign result.conn_state         = state_next;
    assign result.flags              = flags_next;
    assign result.retrans_count      = retrans_next;
    assign result.reorder_count      = reorder_next;
    assign result.initiator_last_ack = i_ack_next;
    assign result.responder_last_ack = r_ack_next;

endmodule

// File: rtl/tcst_out_stage.sv
module tcst_out_stage
    import tcst_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_result,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tcst_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [SLACK_W-1:0] cfg_wdata = '0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_syn_bit = 1'b0;
    logic               s_ack_bit = 1'b0;
    logic               s_fin_bit = 1'b0;
    logic               s_rst_bit = 1'b0;
    logic [SEQ_W-1:0]   s_seq_number = '0;
    logic [SEQ_W-1:0]   s_ack_number = '0;
    logic               s_from_initiator = 1'b0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [STATE_W-1:0] m_conn_state;
    logic               m_syn_seen;
    logic               m_syn_ack_seen;
    logic               m_handshake_done;
    logic               m_fin_initiator;
    logic               m_fin_responder;
    logic               m_reset_seen;
    logic               m_shutdown_done;
    logic [SEQ_W-1:0]   m_retrans_count;
    logic [SEQ_W-1:0]   m_reorder_count;
    logic [SEQ_W-1:0]   m_initiator_last_ack;
    logic [SEQ_W-1:0]   m_responder_last_ack;

    // when set, neither side idles (long back-to-back stretch)
    logic steady = 1'b0;

    int mismatch_count = 0;
    int sent_count = 0;
    int cycle_count = 0;

    // Shadow copy of the connection tracker
    logic [STATE_W-1:0] tracked_state = ST_UNKNOWN;
    flags_t             tracked_flags = '0;
    logic [SEQ_W-1:0]   init_seq_last = '0;
    logic [SEQ_W-1:0]   resp_seq_last = '0;
    logic [SEQ_W-1:0]   init_ack_last = '0;
    logic [SEQ_W-1:0]   resp_ack_last = '0;
    logic [SEQ_W-1:0]   retrans_total = '0;
    logic [SEQ_W-1:0]   reorder_total = '0;
    logic [SLACK_W-1:0] slack_setting = SLACK_RESET;

    // connection views predicted for packets already transferred in
    result_t conn_view_q[$];

    tcp_connection_state_tracker_unit i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_syn_bit            (s_syn_bit),
        .s_ack_bit            (s_ack_bit),
        .s_fin_bit            (s_fin_bit),
        .s_rst_bit            (s_rst_bit),
        .s_seq_number         (s_seq_number),
        .s_ack_number         (s_ack_number),
        .s_from_initiator     (s_from_initiator),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_conn_state         (m_conn_state),
        .m_syn_seen           (m_syn_seen),
        .m_syn_ack_seen       (m_syn_ack_seen),
        .m_handshake_done     (m_handshake_done),
        .m_fin_initiator      (m_fin_initiator),
        .m_fin_responder      (m_fin_responder),
        .m_reset_seen         (m_reset_seen),
        .m_shutdown_done      (m_shutdown_done),
        .m_retrans_count      (m_retrans_count),
        .m_reorder_count      (m_reorder_count),
        .m_initiator_last_ack (m_initiator_last_ack),
        .m_responder_last_ack (m_responder_last_ack)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: run timed out", $time);
        $display("status: fail");
        $finish;
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 14);
    end

    // Connection update for one packet; returns the view after the update.
    // Priority: RST, pure SYN, SYN-ACK, FIN, then ACK / no flags.
    function automatic result_t advance_connection(input pkt_t p);
        logic [SEQ_W-1:0] stored;
        result_t          view;
        if (p.rst_bit) begin
            tracked_flags.reset_seen = 1'b1;
            tracked_flags.shutdown_done = 1'b1;
            tracked_state = ST_CLOSED;
        end else if (p.syn_bit && !p.ack_bit) begin
            if (tracked_state == ST_UNKNOWN || tracked_state == ST_CLOSED) begin
                tracked_flags.syn_opened = 1'b1;
                tracked_state = ST_SYN_SENT;
            end
            if (p.from_initiator)
                init_seq_last = p.seq_number;
        end else if (p.syn_bit) begin
            if (tracked_state == ST_SYN_SENT) begin
                tracked_flags.synack_rcvd = 1'b1;
                tracked_state = ST_SYN_RECEIVED;
            end
            if (!p.from_initiator) begin
                resp_seq_last = p.seq_number;
                resp_ack_last = p.ack_number;
            end
        end else if (p.fin_bit) begin
            if (p.from_initiator)
                tracked_flags.fin_initiator = 1'b1;
            else
                tracked_flags.fin_responder = 1'b1;
            if (tracked_state == ST_ESTABLISHED)
                tracked_state = p.from_initiator ? ST_FIN_WAIT1 : ST_CLOSE_WAIT;
            else if (tracked_state == ST_FIN_WAIT2 && !p.from_initiator)
                tracked_state = ST_TIME_WAIT;
            else if (tracked_state == ST_CLOSE_WAIT && !p.from_initiator)
                tracked_state = ST_LAST_ACK;
            else if (tracked_state == ST_FIN_WAIT1 && !p.from_initiator)
                tracked_state = ST_CLOSING;
            else if (tracked_flags.fin_initiator && tracked_flags.fin_responder)
                tracked_flags.shutdown_done = 1'b1;
        end else begin
            if (p.ack_bit) begin
                if (tracked_state == ST_SYN_RECEIVED && p.from_initiator) begin
                    tracked_flags.handshake_done = 1'b1;
                    tracked_state = ST_ESTABLISHED;
                end else if (tracked_state == ST_FIN_WAIT1) begin
                    tracked_state = ST_FIN_WAIT2;
                end else if (tracked_state == ST_CLOSING) begin
                    tracked_state = ST_TIME_WAIT;
                end else if (tracked_state == ST_LAST_ACK) begin
                    tracked_state = ST_CLOSED;
                    tracked_flags.shutdown_done = 1'b1;
                end
                if (p.from_initiator)
                    init_ack_last = p.ack_number;
                else
                    resp_ack_last = p.ack_number;
            end
            // sequence check against this side's last sequence (zero = unset)
            stored = p.from_initiator ? init_seq_last : resp_seq_last;
            if (stored != '0) begin
                if (p.seq_number < stored) begin
                    if (retrans_total != '1)
                        retrans_total++;
                end else if ({1'b0, p.seq_number} > {1'b0, stored} + slack_setting) begin
                    if (reorder_total != '1)
                        reorder_total++;
                end
                if (p.from_initiator)
                    init_seq_last = p.seq_number;
                else
                    resp_seq_last = p.seq_number;
            end
        end
        view.conn_state = tracked_state;
        view.flags = tracked_flags;
        view.retrans_count = retrans_total;
        view.reorder_count = reorder_total;
        view.initiator_last_ack = init_ack_last;
        view.responder_last_ack = resp_ack_last;
        return view;
    endfunction

    function automatic pkt_t make_pkt(input logic syn, input logic ack, input logic fin,
                                      input logic rst, input logic [SEQ_W-1:0] seq,
                                      input logic [SEQ_W-1:0] ackn, input logic init);
        pkt_t p;
        p.syn_bit = syn;
        p.ack_bit = ack;
        p.fin_bit = fin;
        p.rst_bit = rst;
        p.seq_number = seq;
        p.ack_number = ackn;
        p.from_initiator = init;
        return p;
    endfunction

    function automatic pkt_t random_pkt();
        return make_pkt(1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        $urandom, $urandom, 1'($urandom_range(1)));
    endfunction

    // Next sequence number for one side: mostly in-window, some going back,
    // some jumping past the slack.
    function automatic logic [SEQ_W-1:0] next_seq(input logic [SEQ_W-1:0] cur);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return cur + $urandom_range(32'(slack_setting), 0);
        else if (pick < 85)
            return cur - $urandom_range(1000, 1);
        else
            return cur + slack_setting + $urandom_range(100000, 1);
    endfunction

    // One packet transfer in, with random idle cycles ahead of it
    task automatic send_packet(input pkt_t p);
        if (!steady) begin
            while ($urandom_range(99) < 14) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_syn_bit <= p.syn_bit;
        s_ack_bit <= p.ack_bit;
        s_fin_bit <= p.fin_bit;
        s_rst_bit <= p.rst_bit;
        s_seq_number <= p.seq_number;
        s_ack_number <= p.ack_number;
        s_from_initiator <= p.from_initiator;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        conn_view_q.push_back(advance_connection(p));
        sent_count++;
    endtask

    // Stop sending and wait until every outstanding view has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (conn_view_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_slack(input logic [SLACK_W-1:0] value);
        drain_results();
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        slack_setting = value;
        @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
                               input logic [SEQ_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (conn_view_q.size() == 0) begin
                $display("%0t: result transfer with nothing outstanding", $time);
                mismatch_count++;
            end else begin
                want = conn_view_q.pop_front();
                check_field("conn_state", SEQ_W'(want.conn_state), SEQ_W'(m_conn_state));
                check_field("syn_opened", SEQ_W'(want.flags.syn_opened),
                            SEQ_W'(m_syn_seen));
                check_field("synack_rcvd", SEQ_W'(want.flags.synack_rcvd),
                            SEQ_W'(m_syn_ack_seen));
                check_field("handshake_done", SEQ_W'(want.flags.handshake_done),
                            SEQ_W'(m_handshake_done));
                check_field("fin_initiator", SEQ_W'(want.flags.fin_initiator),
                            SEQ_W'(m_fin_initiator));
                check_field("fin_responder", SEQ_W'(want.flags.fin_responder),
                            SEQ_W'(m_fin_responder));
                check_field("reset_seen", SEQ_W'(want.flags.reset_seen),
                            SEQ_W'(m_reset_seen));
                check_field("shutdown_done", SEQ_W'(want.flags.shutdown_done),
                            SEQ_W'(m_shutdown_done));
                check_field("retrans_count", want.retrans_count, m_retrans_count);
                check_field("reorder_count", want.reorder_count, m_reorder_count);
                check_field("initiator_last_ack", want.initiator_last_ack,
                            m_initiator_last_ack);
                check_field("responder_last_ack", want.responder_last_ack,
                            m_responder_last_ack);
            end
        end
    end

    // Open, data with all sequence-check outcomes, active close, RST
    task automatic test_handshake_and_data();
        // ACK before any SYN
        send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_1234, '1, 1'b1));
        // no flags at all
        send_packet(make_pkt(1'b0, 1'b0, 1'b0, 1'b0, '1, '0, 1'b0));
        // SYN
        send_packet(make_pkt(1'b1, 1'b0, 1'b0, 1'b0, 32'hFFFF_F000, '0, 1'b1));
        // SYN-ACK
        send_packet(make_pkt(1'b1, 1'b1, 1'b0, 1'b0, 32'd100, 32'hFFFF_F001, 1'b0));
        // ACK, jump past slack
        send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FC00, 32'd101, 1'b1));
        // stored plus slack exceeds 32 bits: must not wrap
        send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, '1, 32'd101, 1'b1));
        // retransmission
        send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFE, 32'd101, 1'b1));
        // exactly at the slack
        send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'd1560, '1, 1'b0));
        // one past the slack
        send_packet(make_pkt(1'b0, 1'b0, 1'b0, 1'b0, 32'd3021, '0, 1'b0));
        // stray SYN-ACK
        send_packet(make_pkt(1'b1, 1'b1, 1'b0, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
        // FIN beats ACK
        send_packet(make_pkt(1'b0, 1'b1, 1'b1, 1'b0, 32'h1, 32'h2, 1'b1));
        // to fin_wait2
        send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'd3022, 32'h3, 1'b0));
        // to time-wait
        send_packet(make_pkt(1'b0, 1'b0, 1'b1, 1'b0, 32'h4, 32'h5, 1'b0));
        // both FINs, no move
        send_packet(make_pkt(1'b0, 1'b0, 1'b1, 1'b0, 32'h6, 32'h7, 1'b1));
        // RST beats all
        send_packet(make_pkt(1'b1, 1'b1, 1'b1, 1'b1, 32'h8, 32'h9, 1'b1));
    endtask

    // Passive close through close-wait and last-ack
    task automatic test_close_paths();
        // SYN from responder
        send_packet(make_pkt(1'b1, 1'b0, 1'b0, 1'b0, 32'hAAAA_AAAA, '1, 1'b0));
        send_packet(make_pkt(1'b1, 1'b1, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        // wrong side, no move
        send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'h8000_0000, 32'h1, 1'b0));
        // established
        send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'h1, 32'h8000_0001, 1'b1));
        // close-wait
        send_packet(make_pkt(1'b0, 1'b0, 1'b1, 1'b0, 32'h2, 32'h3, 1'b0));
        // last-ack
        send_packet(make_pkt(1'b0, 1'b0, 1'b1, 1'b0, 32'h4, 32'h5, 1'b0));
        // closed
        send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, 32'h8000_0100, 32'h6, 1'b0));
    endtask

    // One well-formed connection with random content, a little noise mixed in
    task automatic run_session();
        logic [SEQ_W-1:0] isn;
        logic [SEQ_W-1:0] rsn;
        logic [SEQ_W-1:0] cur_i;
        logic [SEQ_W-1:0] cur_r;
        logic [SEQ_W-1:0] seq;
        logic             side;
        int               n_data;
        n_data = $urandom_range(20, 2);
        isn = ($urandom_range(9) == 0) ? '0 : $urandom;
        rsn = $urandom;
        // a SYN only opens from unknown or closed; usually tear down first
        if (tracked_state != ST_UNKNOWN && tracked_state != ST_CLOSED &&
            $urandom_range(9) != 0)
            send_packet(make_pkt(1'b0, 1'($urandom_range(1)), 1'b0, 1'b1, $urandom,
                                 $urandom, 1'($urandom_range(1))));
        send_packet(make_pkt(1'b1, 1'b0, 1'b0, 1'b0, isn, $urandom,
                             $urandom_range(9) != 0));
        send_packet(make_pkt(1'b1, 1'b1, 1'b0, 1'b0, rsn, isn + 1,
                             $urandom_range(9) == 0));
        send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, isn + 1, rsn + 1,
                             $urandom_range(9) != 0));
        if ($urandom_range(19) == 0)
            drain_results();
        cur_i = isn + 1;
        cur_r = rsn + 1;
        repeat (n_data) begin
            if ($urandom_range(99) < 8)
                send_packet(random_pkt());
            side = 1'($urandom_range(1));
            seq = next_seq(side ? cur_i : cur_r);
            send_packet(make_pkt(1'b0, $urandom_range(9) != 0, 1'b0, 1'b0, seq, $urandom,
                                 side));
            if (side)
                cur_i = seq;
            else
                cur_r = seq;
        end
        case ($urandom_range(3))
            0: begin // active close
                send_packet(make_pkt(1'b0, 1'b1, 1'b1, 1'b0, cur_i, $urandom, 1'b1));
                send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, cur_r + 1, $urandom, 1'b0));
                send_packet(make_pkt(1'b0, 1'b1, 1'b1, 1'b0, cur_r + 1, $urandom, 1'b0));
                send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, cur_i + 1, $urandom, 1'b1));
            end
            1: begin // passive close
                send_packet(make_pkt(1'b0, 1'b1, 1'b1, 1'b0, cur_r, $urandom, 1'b0));
                send_packet(make_pkt(1'b0, 1'b1, 1'b1, 1'b0, cur_i, $urandom, 1'b1));
                send_packet(make_pkt(1'b0, 1'b0, 1'b1, 1'b0, cur_r, $urandom, 1'b0));
                send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, cur_i + 1, $urandom,
                                     1'($urandom_range(1))));
            end
            2: begin // simultaneous close
                send_packet(make_pkt(1'b0, 1'b1, 1'b1, 1'b0, cur_i, $urandom, 1'b1));
                send_packet(make_pkt(1'b0, 1'b1, 1'b1, 1'b0, cur_r, $urandom, 1'b0));
                send_packet(make_pkt(1'b0, 1'b1, 1'b0, 1'b0, cur_r + 1, $urandom,
                                     1'($urandom_range(1))));
                send_packet(make_pkt(1'b0, 1'b0, 1'b1, 1'b0, $urandom, $urandom,
                                     1'($urandom_range(1))));
            end
            default: begin
                send_packet(make_pkt(1'b0, 1'($urandom_range(1)), 1'b0, 1'b1, $urandom,
                                     $urandom, 1'($urandom_range(1))));
            end
        endcase
    endtask

    task automatic test_random_traffic(input int count);
        int stop_at;
        stop_at = sent_count + count;
        while (sent_count < stop_at)
            run_session();
    endtask

    // Slack at zero, at its maximum (back to back), at random, and at one
    task automatic test_slack_extremes();
        write_slack('0);
        test_random_traffic(300);
        write_slack('1);
        steady = 1'b1;
        test_random_traffic(300);
        steady = 1'b0;
        write_slack(16'($urandom_range(65535)));
        test_random_traffic(300);
        write_slack(16'd1);
        test_random_traffic(300);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_handshake_and_data();
        test_close_paths();
        test_random_traffic(400);
        test_slack_extremes();
        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
